>>> rtl/mea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mea_pkg;

	// fixed field widths of the request and result items
	localparam int OP_W   = 4;
	localparam int MONO_W = 64;
	localparam int VI_W   = 3;
	localparam int POW_W  = 8;
	localparam int DEG_W  = 11;

	localparam logic [DEG_W-1:0] DEG_MAX = 11'd2047;

	// item widths on the stream ports, padded to whole bytes
	localparam int IN_W  = 144;
	localparam int OUT_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_MUL  = 4'd0,
		OP_LCM  = 4'd1,
		OP_DIVM = 4'd2,
		OP_DIVV = 4'd3,
		OP_MULV = 4'd4,
		OP_DROP = 4'd5,
		OP_SQRT = 4'd6,
		OP_POW  = 4'd7,
		OP_SEP  = 4'd8
	} op_t;

	// per-slot status handed from a lane to the merge stage
	typedef struct packed {
		logic fail;
		logic ovf;
	} lane_flags_t;

endpackage

`default_nettype wire

>>> rtl/mea_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module mea_lane #(
	parameter int IDX      = 0,
	parameter int EXP_BITS = 8
) (
	input  wire                             clk,
	input  wire                             load,
	input  wire mea_pkg::op_t               op,
	input  wire [EXP_BITS-1:0]              a,
	input  wire [EXP_BITS-1:0]              b,
	input  wire [mea_pkg::VI_W-1:0]         vi,
	input  wire [mea_pkg::POW_W-1:0]        pw,
	output logic [EXP_BITS-1:0]             val_s1,
	output mea_pkg::lane_flags_t            flags_s1
);

	// wide enough for a * pw as well as a + b
	localparam int RW = EXP_BITS + mea_pkg::POW_W;
	localparam logic [RW-1:0] MX = RW'((1 << EXP_BITS) - 1);

	logic [RW-1:0]        a_w;
	logic [RW-1:0]        b_w;
	logic [RW-1:0]        r;
	logic                 hit;
	logic                 fail;
	logic [EXP_BITS-1:0]  val_c;
	logic                 ovf_c;

	assign a_w = RW'(a);
	assign b_w = RW'(b);
	assign hit = (vi == mea_pkg::VI_W'(IDX));

	always_comb begin
		r    = a_w;
		fail = 1'b0;
		case (op)
			mea_pkg::OP_MUL:  r = a_w + b_w;
			mea_pkg::OP_LCM:  r = (a_w > b_w) ? a_w : b_w;
			mea_pkg::OP_DIVM: begin
				fail = (b_w > a_w);
				r    = a_w - b_w;
			end
			mea_pkg::OP_DIVV: begin
				// zero slot at the chosen variable cannot be divided
				fail = hit && (a == '0);
				r    = hit ? (a_w - RW'(1)) : a_w;
			end
			mea_pkg::OP_MULV: r = hit ? (a_w + RW'(1)) : a_w;
			mea_pkg::OP_DROP: r = hit ? '0 : a_w;
			mea_pkg::OP_SQRT: begin
				fail = a[0];
				r    = a_w >> 1;
			end
			mea_pkg::OP_POW:  r = a_w * RW'(pw);
			mea_pkg::OP_SEP:  r = RW'(a != '0);
			default:          fail = 1'b1;
		endcase
	end

	// clamp at the slot maximum
	always_comb begin
		ovf_c = (r > MX);
		val_c = ovf_c ? MX[EXP_BITS-1:0] : r[EXP_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_s1        <= val_c;
			flags_s1.fail <= fail;
			flags_s1.ovf  <= ovf_c;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mea_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module mea_merge #(
	parameter int NUM_SLOTS = 8,
	parameter int EXP_BITS  = 8
) (
	input  wire                              clk,
	input  wire                              load,
	input  wire [EXP_BITS-1:0]               vals_s1 [NUM_SLOTS],
	input  wire mea_pkg::lane_flags_t        flags_s1 [NUM_SLOTS],
	input  wire                              range_fail_s1,
	output logic [mea_pkg::MONO_W-1:0]       res_s2,
	output logic [mea_pkg::DEG_W-1:0]        deg_s2,
	output logic                             ok_s2,
	output logic                             ovf_s2
);

	// sum of up to eight slots fits in three extra bits
	localparam int SUM_W = EXP_BITS + 3;
	localparam int AW    = (SUM_W > mea_pkg::DEG_W) ? SUM_W : mea_pkg::DEG_W;

	logic [AW-1:0]                sum;
	logic                         ok_c;
	logic                         ovf_c;
	logic [mea_pkg::MONO_W-1:0]   res_c;
	logic [mea_pkg::DEG_W-1:0]    deg_c;

	always_comb begin
		sum   = '0;
		ok_c  = !range_fail_s1;
		ovf_c = 1'b0;
		res_c = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sum   = sum + AW'(vals_s1[i]);
			ok_c  = ok_c & !flags_s1[i].fail;
			ovf_c = ovf_c | flags_s1[i].ovf;
			res_c[i*EXP_BITS +: EXP_BITS] = vals_s1[i];
		end
		deg_c = (sum > AW'(mea_pkg::DEG_MAX)) ? mea_pkg::DEG_MAX : sum[mea_pkg::DEG_W-1:0];
		// a failed request reports the constant 1 with no overflow
		if (!ok_c) begin
			res_c = '0;
			deg_c = '0;
			ovf_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_c;
			deg_s2 <= deg_c;
			ok_s2  <= ok_c;
			ovf_s2 <= ovf_c;
		end
	end

endmodule

`default_nettype wire

>>> rtl/monomial_exponent_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// monomial exponent alu: slot-wise arithmetic on dense exponent vectors
// input stream (s_axis): one request item per handshake, an operation code,
// two packed exponent vectors, a variable index and a power
// output stream (m_axis): one result item per request, in request order,
// with the result vector, its total degree, a success flag and an
// overflow flag; a failed request returns all zero with ok low
// one lane per active exponent slot computes and saturates its slot in the
// first stage; the merge stage sums the degree and folds the flags
// each item is registered in the lane stage, then in the merge output register
// throughput: one item per cycle while m_axis_tready is held high, with no gaps
// between back-to-back items; when the receiver stalls, both stages fill and
// s_axis_tready drops; an item held in the output register does not stop the
// first stage from taking a new item while that stage is empty
// reset clears both stage valid bits, so no result is presented and the
// block takes an item in the first cycle after reset is released
module monomial_exponent_alu #(
	parameter int NUM_VARS = 8,
	parameter int EXP_BITS = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// req_type[3:0], lhs_exps[67:4], rhs_exps[131:68], var_index[134:132],
	// power[142:135], zero pad[143]
	input  wire [mea_pkg::IN_W-1:0]      s_axis_tdata,
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	// result_exps[63:0], total_degree[74:64], ok[75], overflow[76],
	// zero pad[79:77]
	output logic [mea_pkg::OUT_W-1:0]    m_axis_tdata,
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready
);

	// slots that fit in the 64-bit vector
	localparam int NUM_SLOTS = (NUM_VARS * EXP_BITS > mea_pkg::MONO_W) ?
		(mea_pkg::MONO_W / EXP_BITS) : NUM_VARS;

	mea_pkg::op_t                     op;
	logic [mea_pkg::MONO_W-1:0]       lhs;
	logic [mea_pkg::MONO_W-1:0]       rhs;
	logic [mea_pkg::VI_W-1:0]         vi;
	logic [mea_pkg::POW_W-1:0]        pw;

	logic                             v1_q;
	logic                             v2_q;
	logic                             en1;
	logic                             en2;
	logic                             ld1;
	logic                             ld2;

	logic [EXP_BITS-1:0]              vals_s1 [NUM_SLOTS];
	mea_pkg::lane_flags_t             flags_s1 [NUM_SLOTS];
	logic                             range_fail_s1;

	logic [mea_pkg::MONO_W-1:0]       res_s2;
	logic [mea_pkg::DEG_W-1:0]        deg_s2;
	logic                             ok_s2;
	logic                             ovf_s2;

	// unpack the request item
	assign op  = mea_pkg::op_t'(s_axis_tdata[3:0]);
	assign lhs = s_axis_tdata[67:4];
	assign rhs = s_axis_tdata[131:68];
	assign vi  = s_axis_tdata[134:132];
	assign pw  = s_axis_tdata[142:135];

	// each stage advances when the one after it is empty or draining
	assign en2 = !v2_q || m_axis_tready;
	assign en1 = !v1_q || en2;
	assign ld1 = s_axis_tvalid && en1;
	assign ld2 = v1_q && en2;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = v2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (en1) begin
				v1_q <= s_axis_tvalid;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
		end
	end

	// divide by a variable beyond the active slots has nothing to divide
	always_ff @(posedge clk) begin
		if (ld1) begin
			range_fail_s1 <= (op == mea_pkg::OP_DIVV) &&
				({1'b0, vi} >= (mea_pkg::VI_W + 1)'(NUM_SLOTS));
		end
	end

	// one lane per active slot
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_lane
		mea_lane #(
			.IDX      (i),
			.EXP_BITS (EXP_BITS)
		) u_lane (
			.clk      (clk),
			.load     (ld1),
			.op       (op),
			.a        (lhs[i*EXP_BITS +: EXP_BITS]),
			.b        (rhs[i*EXP_BITS +: EXP_BITS]),
			.vi       (vi),
			.pw       (pw),
			.val_s1   (vals_s1[i]),
			.flags_s1 (flags_s1[i])
		);
	end

	// degree sum, flag fold and output register
	mea_merge #(
		.NUM_SLOTS (NUM_SLOTS),
		.EXP_BITS  (EXP_BITS)
	) u_merge (
		.clk           (clk),
		.load          (ld2),
		.vals_s1       (vals_s1),
		.flags_s1      (flags_s1),
		.range_fail_s1 (range_fail_s1),
		.res_s2        (res_s2),
		.deg_s2        (deg_s2),
		.ok_s2         (ok_s2),
		.ovf_s2        (ovf_s2)
	);

	assign m_axis_tdata = {3'b000, ovf_s2, ok_s2, deg_s2, res_s2};

endmodule

`default_nettype wire
